/* rtl/stp_pkg.sv */
// Shared types, widths and codes for the string to unsigned parser.
// Used by stp_step, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package stp_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int POSITION_BITS = 16;

    // Stream widths; the data widths are rounded up to whole bytes.
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = ((VALUE_BITS + POSITION_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    localparam logic [VALUE_BITS-1:0]    VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};

    // Conversion phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    // Digit status.
    localparam logic [1:0] DS_NONE = 2'd0;
    localparam logic [1:0] DS_SOME = 2'd1;
    localparam logic [1:0] DS_OVER = 2'd2;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_ONE  = 6'd1;
    localparam logic [5:0] BASE_BIN  = 6'd2;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_TOP  = 6'd36;

    localparam logic [5:0] NOT_DIGIT = 6'd63;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [2:0]               phase;
        logic [VALUE_BITS-1:0]    acc;
        logic [5:0]               base;
        logic [1:0]               ds;
        logic                     neg;
        logic [POSITION_BITS-1:0] pos;
    } state_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    value;
        logic [POSITION_BITS-1:0] stop_position;
        logic                     converted;
        logic                     overflowed;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase: PH_IDLE,
        acc:   '0,
        base:  '0,
        ds:    DS_NONE,
        neg:   1'b0,
        pos:   '0
    };

endpackage

/* rtl/stp_step.sv */
// Next-state and result logic for one character of the parser.
// Purely combinational; uses the types and codes of stp_pkg.
`timescale 1ns / 1ps

module stp_step (
    input  stp_pkg::state_t  cur,
    input  logic [7:0]       ch,
    input  logic             start_req,
    input  logic [5:0]       base,
    output stp_pkg::state_t  state_next,
    output logic             emit,
    output stp_pkg::result_t result
);

    localparam int VB = stp_pkg::VALUE_BITS;
    localparam int PB = stp_pkg::POSITION_BITS;
    localparam int PW = VB + 7;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = stp_pkg::NOT_DIGIT;
        if (c >= stp_pkg::CH_0 && c <= stp_pkg::CH_9)
            d = 6'(c - stp_pkg::CH_0);
        else if (c >= stp_pkg::CH_UA && c <= stp_pkg::CH_UZ)
            d = 6'(c - stp_pkg::CH_UA + 8'd10);
        else if (c >= stp_pkg::CH_LA && c <= stp_pkg::CH_LZ)
            d = 6'(c - stp_pkg::CH_LA + 8'd10);
        return d;
    endfunction

    logic [2:0]    ph;
    logic [VB-1:0] acc;
    logic [5:0]    b;
    logic [1:0]    ds;
    logic          ng;
    logic [PB-1:0] pos;
    logic [PB-1:0] idx;
    logic          bad_base;
    logic          blank;
    logic          first_char;
    logic          go_digits;
    logic [5:0]    d;
    logic [PW-1:0] prod;

    always_comb
    begin
        ph   = cur.phase;
        acc  = cur.acc;
        b    = cur.base;
        ds   = cur.ds;
        ng   = cur.neg;
        pos  = cur.pos;
        idx  = '0;
        emit = 1'b0;
        go_digits  = 1'b0;
        first_char = 1'b0;
        bad_base   = 1'b0;
        d    = digit_of(ch);
        blank = (ch == stp_pkg::CH_SPACE) || (ch == stp_pkg::CH_TAB) ||
                (ch == stp_pkg::CH_NL);

        if (start_req)
        begin
            acc = '0;
            ds  = stp_pkg::DS_NONE;
            ng  = 1'b0;
            pos = '0;
            b   = base;
            ph  = stp_pkg::PH_LEAD;
            bad_base = (base == stp_pkg::BASE_ONE) || (base > stp_pkg::BASE_TOP);
        end

        if (bad_base)
        begin
            // An unusable base answers at once with an empty result.
            emit = 1'b1;
            ph   = stp_pkg::PH_IDLE;
        end
        else if (ph != stp_pkg::PH_IDLE)
        begin
            idx = pos;
            if (pos != stp_pkg::POS_MAX)
                pos = pos + PB'(1);

            if (ph == stp_pkg::PH_LEAD)
            begin
                priority if (blank)
                begin
                end
                else if (ch == stp_pkg::CH_MINUS)
                begin
                    ng = 1'b1;
                    ph = stp_pkg::PH_SIGNED;
                end
                else if (ch == stp_pkg::CH_PLUS)
                    ph = stp_pkg::PH_SIGNED;
                else
                    first_char = 1'b1;
            end
            else if (ph == stp_pkg::PH_SIGNED)
                first_char = 1'b1;
            else if (ph == stp_pkg::PH_ZERO)
            begin
                priority if ((ch == stp_pkg::CH_LX || ch == stp_pkg::CH_UX) &&
                             (b == stp_pkg::BASE_AUTO || b == stp_pkg::BASE_HEX))
                begin
                    b  = stp_pkg::BASE_HEX;
                    ph = stp_pkg::PH_PREFIX;
                end
                else if ((ch == stp_pkg::CH_LB || ch == stp_pkg::CH_UB) &&
                         (b == stp_pkg::BASE_AUTO || b == stp_pkg::BASE_BIN))
                begin
                    b  = stp_pkg::BASE_BIN;
                    ph = stp_pkg::PH_PREFIX;
                end
                else
                begin
                    // The leading zero counts as a digit; the value stays zero.
                    if (b == stp_pkg::BASE_AUTO)
                        b = stp_pkg::BASE_OCT;
                    ds = stp_pkg::DS_SOME;
                    go_digits = 1'b1;
                end
            end
            else
                go_digits = 1'b1;

            if (first_char)
            begin
                if (ch == stp_pkg::CH_0 && (b == stp_pkg::BASE_AUTO ||
                    b == stp_pkg::BASE_HEX || b == stp_pkg::BASE_BIN))
                    ph = stp_pkg::PH_ZERO;
                else
                begin
                    if (b == stp_pkg::BASE_AUTO)
                        b = stp_pkg::BASE_DEC;
                    go_digits = 1'b1;
                end
            end
        end

        prod = PW'(acc) * PW'(b) + PW'(d);

        if (go_digits)
        begin
            if (d < b)
            begin
                ph = stp_pkg::PH_DIGITS;
                if (ds == stp_pkg::DS_OVER || prod > PW'(stp_pkg::VALUE_MAX))
                    ds = stp_pkg::DS_OVER;
                else
                begin
                    acc = prod[VB-1:0];
                    ds  = stp_pkg::DS_SOME;
                end
            end
            else
            begin
                emit = 1'b1;
                ph   = stp_pkg::PH_IDLE;
            end
        end

        state_next.phase = ph;
        state_next.acc   = acc;
        state_next.base  = b;
        state_next.ds    = ds;
        state_next.neg   = ng;
        state_next.pos   = pos;

        if (ds == stp_pkg::DS_OVER)
            result.value = stp_pkg::VALUE_MAX;
        else if (ng)
            result.value = (~acc) + VB'(1);
        else
            result.value = acc;
        result.stop_position = (ds != stp_pkg::DS_NONE) ? idx : '0;
        result.converted     = (ds != stp_pkg::DS_NONE);
        result.overflowed    = (ds == stp_pkg::DS_OVER);
    end

endmodule

/* rtl/string_to_unsigned_parser.sv */
// Top level of the string to unsigned parser: input register, step logic and
// result register. Depends on stp_pkg and stp_step.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one character per item; tuser marks the first item
// of a string and the base in tdata is taken on that item (0 detects it).
// The master channel gives one item per finished conversion: the value and
// the stop position in tdata, the converted and overflow flags in tuser.
// A conversion ends on its first non-digit; characters that arrive while no
// conversion is open are dropped without a result.
// An accepted item sits in the input register, and when it advances the step
// logic writes the result it ends into the result register. One item is
// accepted every cycle while the receiver does not stall; the rate is set by
// the single multiply-by-base and range compare between those two registers.
// Reset clears both valid flags and returns the parser to its idle phase.
// When the receiver stalls, the result register holds its item and the
// input register keeps the next item, whether or not it would give a result;
// tready falls while the input register is full and its item cannot advance.

module string_to_unsigned_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ch [7:0], base [13:8], zero fill [15:14]
    input  logic [stp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // start_req [0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // value [63:0], stop_position [79:64]
    output logic [stp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // converted [0], overflowed [1]
    output logic [stp_pkg::OUT_USER_BITS-1:0]  m_axis_tuser
);

    logic             in_valid_reg;
    logic [7:0]       ch_reg;
    logic             start_reg;
    logic [5:0]       base_reg;

    stp_pkg::state_t  state_reg;
    stp_pkg::state_t  state_next;
    logic             emit;
    stp_pkg::result_t result;
    stp_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ch_reg    <= s_axis_tdata[7:0];
            base_reg  <= s_axis_tdata[13:8];
            start_reg <= s_axis_tuser;
        end
    end

    stp_step u_step (
        .cur        (state_reg),
        .ch         (ch_reg),
        .start_req  (start_reg),
        .base       (base_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stp_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = stp_pkg::OUT_DATA_BITS'({result_reg.stop_position,
                                                    result_reg.value});
    assign m_axis_tuser  = {result_reg.overflowed, result_reg.converted};

endmodule

/* rtl/stp_checker.sv */
// Port-level checks for the string to unsigned parser, bound to its top level.
// Depends on stp_pkg and string_to_unsigned_parser.
`timescale 1ns / 1ps

module stp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [stp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic [stp_pkg::OUT_USER_BITS-1:0]  m_axis_tuser
);

    localparam int VB = stp_pkg::VALUE_BITS;

    // A stalled result item keeps its place and its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // The input side only backs up when a result is stuck downstream.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    // No conversion means a zero value and a zero stop position.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("empty result carries data");

    // Overflow implies a conversion and a saturated value.
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && m_axis_tdata[VB-1:0] == {VB{1'b1}})
        else $error("overflow result not saturated");

endmodule

bind string_to_unsigned_parser stp_checker u_stp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
